### rtl/khrm_pkg.sv
// ----------------------------------------------------------------------------
// khrm_pkg
// Types and codes shared by the key/handler registration map.
// ----------------------------------------------------------------------------
package khrm_pkg;

	localparam int DATA_W = 32;
	localparam int SLOT_W = 10;
	localparam int FILL_W = 11;

	// command codes
	localparam logic CMD_REG  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_CONFLICT = 2'd2;
	localparam logic [1:0] ST_BADSLOT  = 2'd3;

	// lookup transaction as it travels down the cell chain
	typedef struct packed {
		logic              active;
		logic              cmd;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] handler;
		logic [SLOT_W-1:0] idx;
		logic              hit;
		logic [SLOT_W-1:0] hit_slot;
		logic [DATA_W-1:0] hit_key;
		logic [DATA_W-1:0] hit_handler;
	} probe_t;

	// slot write broadcast to every cell
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] handler;
	} wr_t;

endpackage

### rtl/khrm_cell.sv
// ----------------------------------------------------------------------------
// khrm_cell
// One table slot: holds a key and its handler, checks the passing
// transaction against them and hands it on to the next cell.
// ----------------------------------------------------------------------------
module khrm_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic [khrm_pkg::FILL_W-1:0] fill,
	input  khrm_pkg::wr_t          wr,
	input  khrm_pkg::probe_t       p_in,
	output khrm_pkg::probe_t       p_out
);
	import khrm_pkg::*;

	logic [DATA_W-1:0] key_q;
	logic [DATA_W-1:0] handler_q;
	logic              filled;
	logic              match;
	probe_t            p_nxt;
	probe_t            p_q;

	// store the slot contents when this slot is allocated
	always_ff @(posedge clk) begin
		if (wr.en && wr.slot == SLOT_W'(CELL_IDX)) begin
			key_q     <= wr.key;
			handler_q <= wr.handler;
		end
	end

	// compare against the key for a register, against the index for a read
	always_comb begin
		filled = FILL_W'(CELL_IDX) < fill;
		if (p_in.cmd == CMD_REG) begin
			match = key_q == p_in.key;
		end else begin
			match = p_in.idx == SLOT_W'(CELL_IDX);
		end
	end

	// capture this slot on a hit
	always_comb begin
		p_nxt = p_in;
		if (p_in.active && filled && match && !p_in.hit) begin
			p_nxt.hit         = 1'b1;
			p_nxt.hit_slot    = SLOT_W'(CELL_IDX);
			p_nxt.hit_key     = key_q;
			p_nxt.hit_handler = handler_q;
		end
	end

	// advance the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
		end else if (adv) begin
			p_q <= p_nxt;
		end
	end

	assign p_out = p_q;

endmodule

### rtl/key_handler_registration_map.sv
// ----------------------------------------------------------------------------
// key_handler_registration_map
// Table of unique keys bound to handler words; registers keys and reads
// slots back by passing each transaction down a row of slot cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | fields
//  --------+-----------+--------------------+---------------------------------
//  in      | input     | in_valid/in_stall  | cmd, key, handler, slot_index
//  out     | output    | out_valid/out_stall| status, slot, key_out,
//          |           |                    | handler_out
//
// One transaction at a time walks the chain of SLOTS cells, one cell per
// cycle, behind the head register; its result is registered in the output
// register, and the next transaction is taken once that one has finished.
// Reset empties the table at once (fill count to zero).
// A stalled result holds the chain's last stage; a new transaction is taken
// while a finished result still waits in the output register.
// ----------------------------------------------------------------------------
module key_handler_registration_map #(
	parameter int SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [khrm_pkg::DATA_W-1:0]   key,
	input  logic [khrm_pkg::DATA_W-1:0]   handler,
	input  logic [khrm_pkg::SLOT_W-1:0]   slot_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [khrm_pkg::SLOT_W-1:0]   slot,
	output logic [khrm_pkg::DATA_W-1:0]   key_out,
	output logic [khrm_pkg::DATA_W-1:0]   handler_out
);
	import khrm_pkg::*;

	probe_t               p [0:SLOTS];
	probe_t               head;
	probe_t               head_q;
	probe_t               last;
	wr_t                  wr;
	logic [SLOTS:0]       act_vec;
	logic                 busy_q;
	logic [FILL_W-1:0]    fill_q;
	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [DATA_W-1:0]    key_out_q;
	logic [DATA_W-1:0]    handler_out_q;
	logic                 accept;
	logic                 adv;
	logic                 finish;
	logic                 full;
	logic [1:0]           res_status;
	logic [SLOT_W-1:0]    res_slot;
	logic [DATA_W-1:0]    res_key;
	logic [DATA_W-1:0]    res_handler;

	assign accept   = in_valid && !busy_q;
	assign in_stall = busy_q;
	assign last     = p[SLOTS];
	assign adv      = !(last.active && out_valid_q && out_stall);
	assign finish   = last.active && adv;
	assign full     = fill_q >= FILL_W'(SLOTS);

	// form the accepted transaction
	always_comb begin
		head         = '0;
		head.active  = accept;
		head.cmd     = cmd;
		head.key     = key;
		head.handler = handler;
		head.idx     = slot_index;
	end

	// load the head of the chain with the accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else begin
			head_q <= head;
		end
	end

	assign p[0] = head_q;

	// chain of slot cells
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		khrm_cell #(
			.CELL_IDX(i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.fill  (fill_q),
			.wr    (wr),
			.p_in  (p[i]),
			.p_out (p[i+1])
		);
	end

	for (genvar j = 0; j <= SLOTS; j++) begin : g_act
		assign act_vec[j] = p[j].active;
	end

	// decide the result at the end of the chain
	always_comb begin
		res_status  = ST_OK;
		res_slot    = '0;
		res_key     = '0;
		res_handler = '0;
		wr          = '0;
		wr.slot     = fill_q[SLOT_W-1:0];
		wr.key      = last.key;
		wr.handler  = last.handler;
		if (last.cmd == CMD_READ) begin
			if (last.hit) begin
				res_slot    = last.hit_slot;
				res_key     = last.hit_key;
				res_handler = last.hit_handler;
			end else begin
				res_status = ST_BADSLOT;
			end
		end else if (last.hit) begin
			if (last.hit_handler == last.handler) begin
				res_slot    = last.hit_slot;
				res_key     = last.key;
				res_handler = last.handler;
			end else begin
				res_status = ST_CONFLICT;
			end
		end else if (full) begin
			res_status = ST_FULL;
		end else begin
			res_slot    = fill_q[SLOT_W-1:0];
			res_key     = last.key;
			res_handler = last.handler;
			wr.en       = finish;
		end
	end

	// track the transaction in flight and the table fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fill_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (wr.en) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			status_q      <= res_status;
			slot_q        <= res_slot;
			key_out_q     <= res_key;
			handler_out_q <= res_handler;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign slot        = slot_q;
	assign key_out     = key_out_q;
	assign handler_out = handler_out_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(SLOTS))
		else $error("fill count beyond table size");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(act_vec) <= 1)
		else $error("more than one transaction in the chain");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> fill_q == $past(fill_q) + FILL_W'(1))
		else $error("fill count did not advance on allocation");

	a_ok_slot_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_OK) |-> FILL_W'(slot_q) < fill_q)
		else $error("result names an unfilled slot");

	a_busy_tracks_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(act_vec != '0) |-> busy_q)
		else $error("transaction in the chain while idle");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives key_handler_registration_map with a short table of directed
// transactions, then random register/read traffic, checking results against
// typed plan rows or a behavioral copy of the slot table and its search tree.
// ----------------------------------------------------------------------------
module testbench;
	import khrm_pkg::*;

	localparam int TABLE_SLOTS  = 16;
	localparam int PLAN_LEN     = 25;
	localparam int RANDOM_ITEMS = 1625;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 40;
	// about 1650 items plus gaps and stalls, with the limit set several times over
	localparam int CYCLE_LIMIT  = 500000;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] handler;
	} reply_t;

	// one directed transaction; the reply fields count only when typed is set
	typedef struct packed {
		logic              cmd;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] handler;
		logic [SLOT_W-1:0] idx;
		logic              typed;
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
		logic [DATA_W-1:0] key_out;
		logic [DATA_W-1:0] handler_out;
	} plan_row_t;

	localparam plan_row_t PLAN [PLAN_LEN] = '{
		// empty table, then the extreme keys and handlers
		'{CMD_READ, 32'h0, 32'h0, 10'd0, 1'b1, ST_BADSLOT, 10'd0, 32'h0, 32'h0},
		'{CMD_REG, 32'h80000000, 32'ha5a5a5a5, 10'd0, 1'b1, ST_OK, 10'd0,
			32'h80000000, 32'ha5a5a5a5},
		'{CMD_REG, 32'h0, 32'h0, 10'd1023, 1'b1, ST_OK, 10'd1, 32'h0, 32'h0},
		'{CMD_REG, 32'hffffffff, 32'hffffffff, 10'd0, 1'b1, ST_OK, 10'd2,
			32'hffffffff, 32'hffffffff},
		// same key and handler again, then a key bound elsewhere
		'{CMD_REG, 32'h80000000, 32'ha5a5a5a5, 10'd0, 1'b1, ST_OK, 10'd0,
			32'h80000000, 32'ha5a5a5a5},
		'{CMD_REG, 32'h0, 32'h1, 10'd0, 1'b1, ST_CONFLICT, 10'd0, 32'h0, 32'h0},
		'{CMD_READ, 32'hffffffff, 32'h0, 10'd2, 1'b1, ST_OK, 10'd2,
			32'hffffffff, 32'hffffffff},
		'{CMD_READ, 32'h0, 32'h0, 10'd3, 1'b1, ST_BADSLOT, 10'd0, 32'h0, 32'h0},
		// rising keys build the longest possible branch
		'{CMD_REG, 32'h80000001, 32'h11111111, 10'd0, 1'b0, ST_OK, 10'd0, 32'h0, 32'h0},
		'{CMD_REG, 32'h80000010, 32'h22222222, 10'd0, 1'b0, ST_OK, 10'd0, 32'h0, 32'h0},
		'{CMD_REG, 32'h80000100, 32'h33333333, 10'd0, 1'b0, ST_OK, 10'd0, 32'h0, 32'h0},
		'{CMD_REG, 32'h80001000, 32'h44444444, 10'd0, 1'b0, ST_OK, 10'd0, 32'h0, 32'h0},
		'{CMD_REG, 32'h80010000, 32'h55555555, 10'd0, 1'b0, ST_OK, 10'd0, 32'h0, 32'h0},
		'{CMD_REG, 32'h80100000, 32'h66666666, 10'd0, 1'b0, ST_OK, 10'd0, 32'h0, 32'h0},
		'{CMD_REG, 32'h81000000, 32'h77777777, 10'd0, 1'b0, ST_OK, 10'd0, 32'h0, 32'h0},
		'{CMD_REG, 32'h90000000, 32'h88888888, 10'd0, 1'b0, ST_OK, 10'd0, 32'h0, 32'h0},
		'{CMD_REG, 32'ha0000000, 32'h99999999, 10'd0, 1'b0, ST_OK, 10'd0, 32'h0, 32'h0},
		'{CMD_REG, 32'hc0000000, 32'haaaaaaaa, 10'd0, 1'b0, ST_OK, 10'd0, 32'h0, 32'h0},
		'{CMD_REG, 32'he0000000, 32'hbbbbbbbb, 10'd0, 1'b0, ST_OK, 10'd0, 32'h0, 32'h0},
		'{CMD_REG, 32'hf0000000, 32'hcccccccc, 10'd0, 1'b0, ST_OK, 10'd0, 32'h0, 32'h0},
		'{CMD_REG, 32'hfffffffe, 32'hdddddddd, 10'd0, 1'b0, ST_OK, 10'd0, 32'h0, 32'h0},
		// table full, last slot, first slot past the end, top index
		'{CMD_REG, 32'h12345678, 32'h9abcdef0, 10'd0, 1'b1, ST_FULL, 10'd0, 32'h0, 32'h0},
		'{CMD_READ, 32'h0, 32'h0, 10'd15, 1'b0, ST_OK, 10'd0, 32'h0, 32'h0},
		'{CMD_READ, 32'h0, 32'h0, 10'd16, 1'b1, ST_BADSLOT, 10'd0, 32'h0, 32'h0},
		'{CMD_READ, 32'h0, 32'h0, 10'd1023, 1'b1, ST_BADSLOT, 10'd0, 32'h0, 32'h0}
	};

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              cmd;
	logic [DATA_W-1:0] key;
	logic [DATA_W-1:0] handler;
	logic [SLOT_W-1:0] slot_index;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        status;
	logic [SLOT_W-1:0] slot;
	logic [DATA_W-1:0] key_out;
	logic [DATA_W-1:0] handler_out;

	// behavioral copy of the slot table and its tree links
	logic [DATA_W-1:0] map_key     [TABLE_SLOTS];
	logic [DATA_W-1:0] map_handler [TABLE_SLOTS];
	int                lo_link     [TABLE_SLOTS];
	int                hi_link     [TABLE_SLOTS];
	int                used_slots = 0;

	reply_t pending_replies [$];
	int     fail_count   = 0;
	int     cycle_count  = 0;
	bit     hold_request = 1'b0;
	bit     calm         = 1'b0;

	key_handler_registration_map #(
		.SLOTS(TABLE_SLOTS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.key        (key),
		.handler    (handler),
		.slot_index (slot_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.slot       (slot),
		.key_out    (key_out),
		.handler_out(handler_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Work out the reply to one transaction and update the table copy.
	function automatic reply_t table_reply(input logic c, input logic [DATA_W-1:0] k,
			input logic [DATA_W-1:0] h, input logic [SLOT_W-1:0] idx);
		reply_t r;
		int     node;
		int     parent;
		int     child;
		bit     go_lo;
		r = '0;
		// read back a filled slot
		if (c == CMD_READ) begin
			if (idx < used_slots) begin
				r.status  = ST_OK;
				r.slot    = idx;
				r.key     = map_key[idx];
				r.handler = map_handler[idx];
			end else begin
				r.status = ST_BADSLOT;
			end
			return r;
		end
		// walk down from the root until a match or an open link
		node   = 0;
		parent = -1;
		go_lo  = 1'b0;
		for (int steps = 0; used_slots > 0 && steps < TABLE_SLOTS; steps++) begin
			if (map_key[node] == k) begin
				if (map_handler[node] == h) begin
					r.status  = ST_OK;
					r.slot    = SLOT_W'(node);
					r.key     = k;
					r.handler = h;
				end else begin
					r.status = ST_CONFLICT;
				end
				return r;
			end
			go_lo = k < map_key[node];
			child = go_lo ? lo_link[node] : hi_link[node];
			if (child == 0) begin
				parent = node;
				break;
			end
			node = child;
		end
		if (used_slots >= TABLE_SLOTS) begin
			r.status = ST_FULL;
			return r;
		end
		// take the next free slot and hang it under the last node visited
		map_key[used_slots]     = k;
		map_handler[used_slots] = h;
		lo_link[used_slots]     = 0;
		hi_link[used_slots]     = 0;
		if (parent >= 0) begin
			if (go_lo)
				lo_link[parent] = used_slots;
			else
				hi_link[parent] = used_slots;
		end
		r.status  = ST_OK;
		r.slot    = SLOT_W'(used_slots);
		r.key     = k;
		r.handler = h;
		used_slots++;
		return r;
	endfunction

	// Offer one transaction, wait for it to be taken, then queue its reply.
	task automatic offer(input logic c, input logic [DATA_W-1:0] k,
			input logic [DATA_W-1:0] h, input logic [SLOT_W-1:0] idx,
			input bit typed, input reply_t want);
		int     gap;
		reply_t guess;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 27)
			gap = $urandom_range(1, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		key        <= k;
		handler    <= h;
		slot_index <= idx;
		do @(posedge clk); while (in_stall);
		guess = table_reply(c, k, h, idx);
		pending_replies.push_back(typed ? want : guess);
	endtask

	// stimulus: directed table, then random traffic
	initial begin
		plan_row_t         row;
		reply_t            want;
		logic              c;
		logic [DATA_W-1:0] k;
		logic [DATA_W-1:0] h;
		logic [SLOT_W-1:0] idx;
		int                pick;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		cmd        = CMD_REG;
		key        = '0;
		handler    = '0;
		slot_index = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PLAN[i]) begin
			row  = PLAN[i];
			want = '{row.status, row.slot, row.key_out, row.handler_out};
			offer(row.cmd, row.key, row.handler, row.idx, row.typed, want);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// long receiver hold-off while transactions keep coming
			if (n == 300)
				hold_request = 1'b1;
			// pause until every reply is back
			if (n == 800 && pending_replies.size() != 0) begin
				in_valid <= 1'b0;
				while (pending_replies.size() != 0) @(posedge clk);
			end
			calm = (n >= 1000 && n < 1250);

			c   = ($urandom_range(0, 99) < 35) ? CMD_READ : CMD_REG;
			k   = $urandom;
			h   = $urandom;
			idx = SLOT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
				: $urandom_range(0, TABLE_SLOTS + 1));
			// mostly aim at keys already held, or just beside them
			if (c == CMD_REG && used_slots > 0) begin
				pick = $urandom_range(0, used_slots - 1);
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: begin
						k = map_key[pick];
						if ($urandom_range(0, 3) != 0)
							h = map_handler[pick];
					end
					5: k = map_key[pick] + 1;
					6: k = map_key[pick] - 1;
					default: ;
				endcase
			end
			offer(c, k, h, idx, 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// result side: check each transaction, then pick the next stall
	initial begin
		reply_t want;
		int     hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_replies.size() == 0) begin
					$error("unexpected result: status %0d slot %0d", status, slot);
					fail_count++;
				end else begin
					want = pending_replies.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						fail_count++;
					end
					if (slot !== want.slot) begin
						$error("slot: expected %0d, actual %0d", want.slot, slot);
						fail_count++;
					end
					if (key_out !== want.key) begin
						$error("key_out: expected %h, actual %h", want.key, key_out);
						fail_count++;
					end
					if (handler_out !== want.handler) begin
						$error("handler_out: expected %h, actual %h", want.handler, handler_out);
						fail_count++;
					end
				end
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 27);
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
		$display("Some tests failed");
		$finish;
	end

endmodule
